[hdl/sfr_pkg.sv]
// ----------------------------------------------------------------------------
// sfr_pkg: shared definitions for the serial frame receiver
// Sizes, status codes, register indexes and the request structs passed
// between the sequencer, the frame store and the checksum accumulator.
// ----------------------------------------------------------------------------
package sfr_pkg;

    localparam int BUFFER_BYTES   = 64;
    localparam int ADDR_W         = $clog2(BUFFER_BYTES);
    localparam int CNT_W          = $clog2(BUFFER_BYTES + 1);
    localparam int LEN_CMP_W      = ((CNT_W > 8) ? CNT_W : 8) + 1;
    localparam int FRAME_OVERHEAD = 5;
    localparam int LENGTH_POS     = 2;

    localparam int BYTE_W      = 8;
    localparam int STATUS_W    = 3;
    localparam int COUNT_OUT_W = 7;
    localparam int CFG_IDX_W   = 8;

    localparam logic [BYTE_W-1:0] START_BYTE_RESET = 8'h40;
    localparam logic [BYTE_W-1:0] END_BYTE_RESET   = 8'h23;

    // register indexes on the configuration channel
    localparam logic [CFG_IDX_W-1:0] CFG_START_BYTE = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_END_BYTE   = 8'd1;

    // result status codes
    localparam logic [STATUS_W-1:0] STATUS_HUNT    = 3'd0;
    localparam logic [STATUS_W-1:0] STATUS_RECV    = 3'd1;
    localparam logic [STATUS_W-1:0] STATUS_GOOD    = 3'd2;
    localparam logic [STATUS_W-1:0] STATUS_BAD     = 3'd3;
    localparam logic [STATUS_W-1:0] STATUS_CLEARED = 3'd4;
    localparam logic [STATUS_W-1:0] STATUS_WRAPPED = 3'd5;

    // frame store access for one cycle
    typedef struct packed {
        logic              clr;
        logic              we;
        logic [ADDR_W-1:0] waddr;
        logic [BYTE_W-1:0] wdata;
        logic              re;
        logic [ADDR_W-1:0] raddr;
    } store_req_t;

    // checksum accumulator control
    typedef struct packed {
        logic clr;
        logic add;
    } acc_ctrl_t;

endpackage

[hdl/serial_frame_receiver_checksum.sv]
// ----------------------------------------------------------------------------
// serial_frame_receiver_checksum: length-prefixed frame receiver
// Collects received bytes into a frame store, checks the additive checksum
// and end byte of a complete frame and reads a good frame back out.
// ----------------------------------------------------------------------------
// Usage notes
//   s_ channel: one word per received byte. s_tdata = rx_byte, s_tuser = mode
//     (1 clears count, ready flag and store; rx_byte then ignored).
//   m_ channel: one word per result, m_tlast on the final word of an item.
//     Ordinary bytes give one word; a good frame gives one word per frame
//     byte, status "frame good", bytes in store order.
//   cfg channel: cfg_index 0 = start byte, 1 = end byte; always ready, write
//     only while idle. Other indexes are ignored.
//   Timing: one item at a time, s_tready high only in the idle state.
//     Plain byte or clear: result passes through S_EMIT to the output register.
//     Complete frame: checksum pass, compare, store read, then one byte a
//     cycle while m_tready is high; a bad checksum gives a single result
//     word after the compare (frame length <= 64).
//   Reset: count, ready flag and config registers to defaults; store valid
//     bits cleared at once, so no clearing pass is needed.
//   Stall: a low m_tready holds the output word and the readout; the next
//     input word can still be taken while a result waits in the output register.
// ----------------------------------------------------------------------------
module serial_frame_receiver_checksum
    import sfr_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    // received bytes
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [7:0]           s_tdata,     // [7:0] rx_byte
    input  logic                 s_tuser,     // [0] mode
    // results
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [15:0]          m_tdata,     // [6:0] byte_count, [7] frame_ready,
                                              // [15:8] frame_byte
    output logic [2:0]           m_tuser,     // [2:0] status
    output logic                 m_tlast,
    // configuration writes
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [7:0]           cfg_data
);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_SUM  = 5'b00010,   // checksum pass over the frame
        S_TAIL = 5'b00100,   // compare against the checksum byte
        S_READ = 5'b01000,   // good-frame readout
        S_EMIT = 5'b10000    // single result waiting for the output register
    } state_t;

    state_t state_reg, state_next;

    logic [ADDR_W-1:0]   count_reg, count_next;     // receive count
    logic                ready_reg, ready_next;     // frame ready flag
    logic [BYTE_W-1:0]   len_reg, len_next;         // shadow of store[LENGTH_POS]
    logic [BYTE_W-1:0]   start_reg, start_next;
    logic [BYTE_W-1:0]   end_reg, end_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;         // length of frame under check
    logic [CNT_W-1:0]    rd_ptr_reg, rd_ptr_next;   // next store read
    logic [CNT_W-1:0]    ld_idx_reg, ld_idx_next;   // next readout byte
    logic                pipe_valid_reg, pipe_valid_next;
    logic [STATUS_W-1:0] res_status_reg, res_status_next;
    logic [CNT_W-1:0]    res_count_reg, res_count_next;

    logic                m_valid_reg, m_valid_next;
    logic [15:0]         m_data_reg, m_data_next;
    logic [2:0]          m_user_reg, m_user_next;
    logic                m_last_reg, m_last_next;

    store_req_t          store_req;
    acc_ctrl_t           acc_ctrl;
    logic [BYTE_W-1:0]   rdata;
    logic                sum_match;

    logic                s_fire;
    logic                cfg_fire;
    logic                can_load;
    logic [BYTE_W-1:0]   rx_byte;
    logic [BYTE_W-1:0]   len_eff;
    logic [CNT_W-1:0]    cnt_acc;
    logic                complete;
    logic                issue;
    logic                load;
    logic                ld_last;

    sfr_store u_store (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (store_req),
        .rdata   (rdata)
    );

    sfr_accum u_accum (
        .aclk  (aclk),
        .ctrl  (acc_ctrl),
        .din   (rdata),
        .match (sum_match)
    );

    assign s_tready  = (state_reg == S_IDLE);
    assign s_fire    = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;
    assign cfg_fire  = cfg_valid && cfg_ready;
    assign can_load  = !m_valid_reg || m_tready;

    assign rx_byte  = s_tdata;
    assign cnt_acc  = CNT_W'(count_reg) + CNT_W'(1);
    // length byte may be the one being written now
    assign len_eff  = (count_reg == ADDR_W'(LENGTH_POS)) ? rx_byte : len_reg;
    assign complete = LEN_CMP_W'(cnt_acc) >=
                      (LEN_CMP_W'(len_eff) + LEN_CMP_W'(FRAME_OVERHEAD));

    // readout: a new read is issued when the held data can move on
    assign issue   = (!pipe_valid_reg || can_load) && (rd_ptr_reg < cnt_reg);
    assign load    = pipe_valid_reg && can_load;
    assign ld_last = (ld_idx_reg == (cnt_reg - CNT_W'(1)));

    always_comb begin
        state_next      = state_reg;
        count_next      = count_reg;
        ready_next      = ready_reg;
        len_next        = len_reg;
        start_next      = start_reg;
        end_next        = end_reg;
        cnt_next        = cnt_reg;
        rd_ptr_next     = rd_ptr_reg;
        ld_idx_next     = ld_idx_reg;
        pipe_valid_next = pipe_valid_reg;
        res_status_next = res_status_reg;
        res_count_next  = res_count_reg;
        m_valid_next    = m_valid_reg && !m_tready;
        m_data_next     = m_data_reg;
        m_user_next     = m_user_reg;
        m_last_next     = m_last_reg;
        store_req       = '0;
        acc_ctrl        = '0;

        if (cfg_fire) begin
            if (cfg_index == CFG_START_BYTE) begin
                start_next = cfg_data;
            end else if (cfg_index == CFG_END_BYTE) begin
                end_next = cfg_data;
            end
        end

        unique case (state_reg)
            S_IDLE: begin
                if (s_fire) begin
                    state_next = S_EMIT;
                    if (s_tuser) begin
                        store_req.clr   = 1'b1;
                        count_next      = '0;
                        ready_next      = 1'b0;
                        len_next        = '0;
                        res_status_next = STATUS_CLEARED;
                        res_count_next  = '0;
                    end else begin
                        store_req.we    = 1'b1;
                        store_req.waddr = count_reg;
                        store_req.wdata = rx_byte;
                        if (count_reg == ADDR_W'(LENGTH_POS)) begin
                            len_next = rx_byte;
                        end
                        priority if (count_reg == '0 && rx_byte != start_reg) begin
                            res_status_next = STATUS_HUNT;
                            res_count_next  = '0;
                        end else if (!complete) begin
                            if (cnt_acc == CNT_W'(BUFFER_BYTES)) begin
                                count_next      = '0;
                                res_status_next = STATUS_WRAPPED;
                                res_count_next  = '0;
                            end else begin
                                count_next      = cnt_acc[ADDR_W-1:0];
                                res_status_next = STATUS_RECV;
                                res_count_next  = cnt_acc;
                            end
                        end else if (rx_byte != end_reg) begin
                            // end byte wrong: no need for the checksum pass
                            ready_next      = 1'b0;
                            count_next      = '0;
                            res_status_next = STATUS_BAD;
                            res_count_next  = '0;
                        end else begin
                            state_next      = S_SUM;
                            cnt_next        = cnt_acc;
                            rd_ptr_next     = '0;
                            pipe_valid_next = 1'b0;
                            acc_ctrl.clr    = 1'b1;
                        end
                    end
                end
            end

            S_SUM: begin
                // read byte i, add byte i-1 as it arrives
                store_req.re    = 1'b1;
                store_req.raddr = rd_ptr_reg[ADDR_W-1:0];
                acc_ctrl.add    = pipe_valid_reg;
                pipe_valid_next = 1'b1;
                if (rd_ptr_reg == (cnt_reg - CNT_W'(2))) begin
                    state_next = S_TAIL;
                end else begin
                    rd_ptr_next = rd_ptr_reg + CNT_W'(1);
                end
            end

            S_TAIL: begin
                if (sum_match) begin
                    ready_next      = 1'b1;
                    count_next      = (cnt_reg == CNT_W'(BUFFER_BYTES)) ?
                                      '0 : cnt_reg[ADDR_W-1:0];
                    rd_ptr_next     = '0;
                    ld_idx_next     = '0;
                    pipe_valid_next = 1'b0;
                    state_next      = S_READ;
                end else begin
                    ready_next      = 1'b0;
                    count_next      = '0;
                    res_status_next = STATUS_BAD;
                    res_count_next  = '0;
                    state_next      = S_EMIT;
                end
            end

            S_READ: begin
                store_req.re    = issue;
                store_req.raddr = rd_ptr_reg[ADDR_W-1:0];
                if (issue) begin
                    rd_ptr_next = rd_ptr_reg + CNT_W'(1);
                end
                pipe_valid_next = issue || (pipe_valid_reg && !can_load);
                if (load) begin
                    m_valid_next = 1'b1;
                    m_user_next  = STATUS_GOOD;
                    m_data_next  = {rdata, ready_reg, COUNT_OUT_W'(cnt_reg)};
                    m_last_next  = ld_last;
                    ld_idx_next  = ld_idx_reg + CNT_W'(1);
                    if (ld_last) begin
                        state_next = S_IDLE;
                    end
                end
            end

            S_EMIT: begin
                if (can_load) begin
                    m_valid_next = 1'b1;
                    m_user_next  = res_status_reg;
                    m_data_next  = {8'h00, ready_reg, COUNT_OUT_W'(res_count_reg)};
                    m_last_next  = 1'b1;
                    state_next   = S_IDLE;
                end
            end

            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            count_reg      <= '0;
            ready_reg      <= 1'b0;
            len_reg        <= '0;
            start_reg      <= START_BYTE_RESET;
            end_reg        <= END_BYTE_RESET;
            pipe_valid_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            ready_reg      <= ready_next;
            len_reg        <= len_next;
            start_reg      <= start_next;
            end_reg        <= end_next;
            pipe_valid_reg <= pipe_valid_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        cnt_reg        <= cnt_next;
        rd_ptr_reg     <= rd_ptr_next;
        ld_idx_reg     <= ld_idx_next;
        res_status_reg <= res_status_next;
        res_count_reg  <= res_count_next;
        m_data_reg     <= m_data_next;
        m_user_reg     <= m_user_next;
        m_last_reg     <= m_last_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;
    assign m_tlast  = m_last_reg;

`ifndef SYNTHESIS
    // a good-frame word always carries the ready flag
    a_good_sets_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser == STATUS_GOOD) |-> m_tdata[7])
        else $error("good frame word without frame_ready");

    // finishing a readout leaves the final word marked last
    a_readout_ends_last: assert property (@(posedge aclk) disable iff (!aresetn)
        ($past(state_reg == S_READ) && state_reg == S_IDLE) |-> (m_tvalid && m_tlast))
        else $error("readout ended without last word");

    // readout index stays within the frame
    a_readout_in_frame: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_READ) |-> (ld_idx_reg < cnt_reg))
        else $error("readout index beyond frame length");

    // the checksum pass only runs on frames of at least the overhead length
    a_sum_min_length: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_SUM) |-> (cnt_reg >= CNT_W'(FRAME_OVERHEAD)))
        else $error("checksum pass on short frame");
`endif

endmodule

[hdl/sfr_store.sv]
// ----------------------------------------------------------------------------
// sfr_store: frame byte store
// One write port, one registered read port. Per-entry valid bits give the
// all-zero contents after reset and after a clear without a sweep.
// ----------------------------------------------------------------------------
module sfr_store
    import sfr_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  store_req_t        req,
    output logic [BYTE_W-1:0] rdata
);

    logic [BYTE_W-1:0]       mem [BUFFER_BYTES];
    logic [BUFFER_BYTES-1:0] valid_reg;
    logic [BUFFER_BYTES-1:0] valid_next;
    logic [BYTE_W-1:0]       rdata_reg;
    logic                    rvalid_reg;

    always_comb begin
        valid_next = valid_reg;
        if (req.clr) begin
            valid_next = '0;
        end else if (req.we) begin
            valid_next[req.waddr] = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (req.we) begin
            mem[req.waddr] <= req.wdata;
        end
        if (req.re) begin
            rdata_reg  <= mem[req.raddr];
            rvalid_reg <= valid_reg[req.raddr];
        end
    end

    // never-written entries read as zero
    assign rdata = rvalid_reg ? rdata_reg : '0;

endmodule

[hdl/sfr_accum.sv]
// ----------------------------------------------------------------------------
// sfr_accum: checksum accumulator
// 8-bit modulo sum of frame bytes, one byte a cycle while ctrl.add is high,
// with an equality compare of the running sum against the byte on its input.
// ----------------------------------------------------------------------------
module sfr_accum
    import sfr_pkg::*;
(
    input  logic              aclk,
    input  acc_ctrl_t         ctrl,
    input  logic [BYTE_W-1:0] din,
    output logic              match
);

    logic [BYTE_W-1:0] sum_reg;
    logic [BYTE_W-1:0] sum_next;

    always_comb begin
        sum_next = sum_reg;
        if (ctrl.clr) begin
            sum_next = '0;
        end else if (ctrl.add) begin
            sum_next = sum_reg + din;
        end
    end

    always_ff @(posedge aclk) begin
        sum_reg <= sum_next;
    end

    assign match = (sum_reg == din);

endmodule
